>>> rtl/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg
// Shared types, constants and helpers for the grid line-of-sight checker.
// ----------------------------------------------------------------------------
`default_nettype none

package glc_pkg;

   localparam int MaxWidthDef  = 256;
   localparam int MaxHeightDef = 256;

   // coordinate and register widths fixed by the request format
   localparam int CoordW = 8;
   localparam int RegW   = 9;
   // holds any effective grid dimension up to 4096
   localparam int DimW   = 13;
   // Bresenham error term, signed
   localparam int ErrW   = 12;

   localparam logic CsrGridWidth  = 1'b0;
   localparam logic CsrGridHeight = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } walk_state_type;

   typedef struct packed {
      logic              go;
      logic              out_of_range;
      logic [CoordW-1:0] x0;
      logic [CoordW-1:0] y0;
      logic [CoordW-1:0] x1;
      logic [CoordW-1:0] y1;
   } query_cmd_type;

   typedef struct packed {
      logic valid;
      logic path_clear;
      logic out_of_range;
   } query_rsp_type;

   // register value as used: zero counts as one, clamp to the maximum
   function automatic logic [DimW-1:0] eff_dim(input logic [RegW-1:0] value, input int maxv);
      logic [DimW-1:0] res;
      if (value == '0) begin
         res = DimW'(1);
      end else if (int'(value) > maxv) begin
         res = DimW'(maxv);
      end else begin
         res = DimW'(value);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/glc_grid_mem.sv
// ----------------------------------------------------------------------------
// glc_grid_mem
// Occupancy bit store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module glc_grid_mem #(
   parameter int Depth = glc_pkg::MaxWidthDef * glc_pkg::MaxHeightDef,
   parameter int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic             wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic                  rd_data
);

   logic mem_ff [Depth];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/glc_walker.sv
// ----------------------------------------------------------------------------
// glc_walker
// Bresenham walk sequencer: issues one grid read per step and checks the
// returned bit in the following cycle, stopping at the end cell or a blocked cell.
// ----------------------------------------------------------------------------
`default_nettype none

module glc_walker #(
   parameter int MaxWidth = glc_pkg::MaxWidthDef,
   parameter int AddrW    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire glc_pkg::query_cmd_type cmd,
   output logic                        busy,
   output logic                        rd_en,
   output logic [AddrW-1:0]            rd_addr,
   input  wire logic                   rd_data,
   output glc_pkg::query_rsp_type      rsp
);

   localparam int CW = glc_pkg::CoordW;
   localparam int EW = glc_pkg::ErrW;

   glc_pkg::walk_state_type state_ff, state_in;

   logic [CW-1:0]        x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]        ex_ff, ex_in, ey_ff, ey_in;
   logic [CW-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                 neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_clear_ff, rsp_clear_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   logic                 at_end;
   logic signed [EW:0]   e2;
   logic signed [EW:0]   dx_s, dy_s;
   logic                 step_x, step_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= glc_pkg::ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      err_ff       <= err_in;
      rsp_clear_ff <= rsp_clear_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign at_end = (x_ff == ex_ff) && (y_ff == ey_ff);
   assign dx_s   = $signed({{(EW+1-CW){1'b0}}, dx_ff});
   assign dy_s   = $signed({{(EW+1-CW){1'b0}}, dy_ff});
   assign e2     = {err_ff, 1'b0};
   assign step_x = e2 > -dy_s;
   assign step_y = e2 < dx_s;

   assign rd_addr = AddrW'(y_ff) * AddrW'(MaxWidth) + AddrW'(x_ff);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      err_in       = err_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_clear_in = rsp_clear_ff;
      rsp_oor_in   = rsp_oor_ff;
      rd_en        = 1'b0;

      unique case (state_ff)
         glc_pkg::ST_IDLE: begin
            if (cmd.go) begin
               if (cmd.out_of_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_clear_in = 1'b0;
                  rsp_oor_in   = 1'b1;
               end else begin
                  state_in = glc_pkg::ST_WALK;
                  x_in     = cmd.x0;
                  y_in     = cmd.y0;
                  ex_in    = cmd.x1;
                  ey_in    = cmd.y1;
                  dx_in    = (cmd.x1 > cmd.x0) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
                  dy_in    = (cmd.y1 > cmd.y0) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1;
                  neg_x_in = !(cmd.x0 < cmd.x1);
                  neg_y_in = !(cmd.y0 < cmd.y1);
                  err_in   = $signed(EW'(dx_in)) - $signed(EW'(dy_in));
               end
            end
         end
         glc_pkg::ST_WALK: begin
            if (rd_pend_ff && rd_data) begin
               state_in     = glc_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_clear_in = 1'b0;
               rsp_oor_in   = 1'b0;
            end else if (at_end) begin
               state_in     = glc_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_clear_in = 1'b1;
               rsp_oor_in   = 1'b0;
            end else begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               if (step_x) begin
                  x_in = neg_x_ff ? x_ff - 1'b1 : x_ff + 1'b1;
               end
               if (step_y) begin
                  y_in = neg_y_ff ? y_ff - 1'b1 : y_ff + 1'b1;
               end
               err_in = err_ff
                      - (step_x ? $signed(EW'(dy_ff)) : $signed(EW'(0)))
                      + (step_y ? $signed(EW'(dx_ff)) : $signed(EW'(0)));
            end
         end
         default: begin
            state_in = glc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != glc_pkg::ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.path_clear   = rsp_clear_ff;
   assign rsp.out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire

>>> rtl/grid_line_of_sight_check.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_check
// Occupancy grid with Bresenham line-of-sight queries.
// ----------------------------------------------------------------------------
// Load request: no response; busy stays low.
// Query out of grid: response in the cycle after the request, busy stays low.
// Query walking N = max(dx, dy) cells: one grid read per cell, the end cell not read;
// busy while walking, response registered after the walk; stops early at a blocked cell.
// Reset: grid sizes return to 256, walker idle; grid contents undefined until loaded.
// Responses cannot be stalled: rsp_valid marks a single-cycle response.
`default_nettype none

module grid_line_of_sight_check #(
   parameter int MAX_WIDTH  = glc_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = glc_pkg::MaxHeightDef
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_action,
   input  wire logic [glc_pkg::CoordW-1:0]   req_start_x,
   input  wire logic [glc_pkg::CoordW-1:0]   req_start_y,
   input  wire logic [glc_pkg::CoordW-1:0]   req_end_x,
   input  wire logic [glc_pkg::CoordW-1:0]   req_end_y,
   input  wire logic signed [7:0]            req_cell_value,
   output logic                              rsp_valid,
   output logic                              rsp_path_clear,
   output logic                              rsp_out_of_range,
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_index,
   input  wire logic [glc_pkg::RegW-1:0]     csr_wr_data
);

   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrW = $clog2(Depth);
   localparam int DW    = glc_pkg::DimW;
   localparam int CW    = glc_pkg::CoordW;

   logic [glc_pkg::RegW-1:0] grid_width_ff, grid_height_ff;
   logic [DW-1:0]            eff_w, eff_h;
   logic                     accept;
   logic                     start_ok, end_ok;
   logic                     wr_en;
   logic [AddrW-1:0]         wr_addr;
   logic                     rd_en;
   logic [AddrW-1:0]         rd_addr;
   logic                     rd_data;
   glc_pkg::query_cmd_type   cmd;
   glc_pkg::query_rsp_type   rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= glc_pkg::RegW'(256);
         grid_height_ff <= glc_pkg::RegW'(256);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            glc_pkg::CsrGridWidth:  grid_width_ff  <= csr_wr_data;
            glc_pkg::CsrGridHeight: grid_height_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign eff_w = glc_pkg::eff_dim(grid_width_ff, MAX_WIDTH);
   assign eff_h = glc_pkg::eff_dim(grid_height_ff, MAX_HEIGHT);

   assign accept   = start && !busy;
   assign start_ok = (DW'(req_start_x) < eff_w) && (DW'(req_start_y) < eff_h);
   assign end_ok   = (DW'(req_end_x) < eff_w) && (DW'(req_end_y) < eff_h);

   assign wr_en   = accept && !req_action && start_ok;
   assign wr_addr = AddrW'(req_start_y) * AddrW'(MAX_WIDTH) + AddrW'(req_start_x);

   assign cmd.go           = accept && req_action;
   assign cmd.out_of_range = !(start_ok && end_ok);
   assign cmd.x0           = CW'(req_start_x);
   assign cmd.y0           = CW'(req_start_y);
   assign cmd.x1           = CW'(req_end_x);
   assign cmd.y1           = CW'(req_end_y);

   glc_grid_mem #(
      .Depth (Depth),
      .AddrW (AddrW)
   ) u_grid_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cell_value != 8'sd0),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   glc_walker #(
      .MaxWidth (MAX_WIDTH),
      .AddrW    (AddrW)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .busy    (busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp     (rsp)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_path_clear   = rsp.path_clear;
   assign rsp_out_of_range = rsp.out_of_range;

endmodule

`default_nettype wire

>>> test/grid_line_of_sight_check_tb.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_tb
// Self-checking bench for the occupancy grid line-of-sight checker: loads
// cells, fires line queries and compares every response with an in-bench
// line tracer over a shadow copy of the grid. Only cells already loaded are
// ever walked, and grid sizes change between phases when the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module grid_line_of_sight_check_tb;

   localparam bit ActLoad  = 1'b0;
   localparam bit ActQuery = 1'b1;
   localparam int ItemTarget = 2000;
   localparam int GridSide   = glc_pkg::MaxWidthDef;

   typedef bit [glc_pkg::CoordW-1:0] coord_type;

   typedef struct packed {
      bit clear;
      bit oor;
   } verdict_type;

   class sight_line_checker;
      bit          blocked [GridSide*GridSide];
      bit          loaded  [GridSide*GridSide];
      bit [8:0]    width_reg;
      bit [8:0]    height_reg;
      verdict_type expected_verdicts[$];
      int          mismatches;
      int          n_loads;
      int          n_queries;
      int          n_clear;
      int          n_oor;

      function new();
         width_reg  = 9'd256;
         height_reg = 9'd256;
      endfunction

      function int eff_size(bit [8:0] r);
         if (r == 0) return 1;
         if (r > GridSide) return GridSide;
         return int'(r);
      endfunction

      function bit in_grid(int x, int y);
         return x < eff_size(width_reg) && y < eff_size(height_reg);
      endfunction

      function void write_reg(logic idx, bit [8:0] v);
         if (idx == glc_pkg::CsrGridWidth) width_reg = v;
         else height_reg = v;
      endfunction

      // walks the line up to, not including, the end cell; reports the first
      // cell read that was never loaded
      function bit trace_sight_line(input int x0, input int y0, input int x1, input int y1,
                                    output bit hole, output int hx, output int hy);
         int dx, dy, stx, sty, err, e2, x, y;
         dx  = x1 > x0 ? x1 - x0 : x0 - x1;
         dy  = y1 > y0 ? y1 - y0 : y0 - y1;
         stx = x0 < x1 ? 1 : -1;
         sty = y0 < y1 ? 1 : -1;
         err = dx - dy;
         x   = x0;
         y   = y0;
         hole = 1'b0;
         hx   = 0;
         hy   = 0;
         while (x != x1 || y != y1) begin
            if (!loaded[y*GridSide + x]) begin
               hole = 1'b1;
               hx   = x;
               hy   = y;
               return 1'b0;
            end
            if (blocked[y*GridSide + x]) return 1'b0;
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               x   += stx;
            end
            if (e2 < dx) begin
               err += dx;
               y   += sty;
            end
         end
         return 1'b1;
      endfunction

      function void note_request(bit act, coord_type sx, coord_type sy, coord_type ex,
                                 coord_type ey, bit [7:0] val);
         verdict_type v;
         bit          hole;
         int          hx, hy;
         if (act == ActLoad) begin
            n_loads++;
            if (in_grid(int'(sx), int'(sy))) begin
               blocked[sy*GridSide + sx] = (val != 0);
               loaded[sy*GridSide + sx]  = 1'b1;
            end
            return;
         end
         n_queries++;
         if (!in_grid(int'(sx), int'(sy)) || !in_grid(int'(ex), int'(ey))) begin
            v.clear = 1'b0;
            v.oor   = 1'b1;
         end else begin
            v.clear = trace_sight_line(int'(sx), int'(sy), int'(ex), int'(ey), hole, hx, hy);
            v.oor   = 1'b0;
         end
         expected_verdicts.insert(expected_verdicts.size(), v);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, what);
      endfunction

      function void check_response(bit clear, bit oor);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            flag($sformatf("response clear=%0b oor=%0b with no request outstanding",
                           clear, oor));
            return;
         end
         v = expected_verdicts.pop_front();
         if (v.clear) n_clear++;
         if (v.oor) n_oor++;
         if (clear != v.clear)
            flag($sformatf("path_clear expected %0b got %0b", v.clear, clear));
         if (oor != v.oor)
            flag($sformatf("out_of_range expected %0b got %0b", v.oor, oor));
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic         req_action = 1'b0;
   logic [7:0]   req_start_x = '0;
   logic [7:0]   req_start_y = '0;
   logic [7:0]   req_end_x = '0;
   logic [7:0]   req_end_y = '0;
   logic signed [7:0] req_cell_value = '0;
   logic         rsp_valid;
   logic         rsp_path_clear;
   logic         rsp_out_of_range;
   logic         csr_wr_en = 1'b0;
   logic         csr_index = glc_pkg::CsrGridWidth;
   logic [8:0]   csr_wr_data = '0;

   sight_line_checker sb = new();
   int items;
   int phases;
   bit burst_mode;

   grid_line_of_sight_check u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_path_clear   (rsp_path_clear),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // responses first, then the request accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_response(rsp_path_clear, rsp_out_of_range);
         if (start && !busy)
            sb.note_request(req_action, req_start_x, req_start_y, req_end_x, req_end_y,
                            req_cell_value);
      end
   end

   function int draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 18);
   endfunction

   function bit [7:0] load_value();
      return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
   endfunction

   function bit [7:0] fill_value();
      return ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
   endfunction

   function coord_type pick_coord(int dim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return coord_type'($urandom_range(0, 255));
      if (r < 20) return coord_type'($urandom_range(0, dim - 1));
      return coord_type'($urandom_range(0, dim < 24 ? dim : 23));
   endfunction

   function coord_type near_coord(coord_type c);
      int v;
      v = int'(c) + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return coord_type'(v);
   endfunction

   function bit [8:0] pick_dim();
      bit [8:0] extremes[7] = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};
      case ($urandom_range(0, 5))
         0: return extremes[$urandom_range(0, 6)];
         1, 2: return 9'($urandom_range(1, 32));
         3: return 9'($urandom_range(0, 511));
         default: return 9'd256;
      endcase
   endfunction

   // called and returns at a falling edge; start stays high for back-to-back
   task automatic send_req(bit act, coord_type sx, coord_type sy, coord_type ex,
                           coord_type ey, bit [7:0] val);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_end_x      <= ex;
      req_end_y      <= ey;
      req_cell_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      items++;
   endtask

   task automatic load_cell(coord_type x, coord_type y, bit [7:0] val);
      send_req(ActLoad, x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), val);
   endtask

   // loads any never-written cell the walk would read, then sends the query
   task automatic run_query(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
      bit hole;
      int hx, hy;
      if (sb.in_grid(int'(sx), int'(sy)) && sb.in_grid(int'(ex), int'(ey))) begin
         void'(sb.trace_sight_line(int'(sx), int'(sy), int'(ex), int'(ey), hole, hx, hy));
         while (hole) begin
            load_cell(coord_type'(hx), coord_type'(hy), fill_value());
            void'(sb.trace_sight_line(int'(sx), int'(sy), int'(ex), int'(ey), hole, hx, hy));
         end
      end
      send_req(ActQuery, sx, sy, ex, ey, 8'($urandom_range(0, 255)));
   endtask

   task automatic settle(int extra);
      start <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_grid(bit [8:0] w, bit [8:0] h);
      csr_wr_en   <= 1'b1;
      csr_index   <= glc_pkg::CsrGridWidth;
      csr_wr_data <= w;
      @(negedge clock);
      csr_index   <= glc_pkg::CsrGridHeight;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(glc_pkg::CsrGridWidth, w);
      sb.write_reg(glc_pkg::CsrGridHeight, h);
      phases++;
   endtask

   task automatic random_request();
      int        w, h;
      coord_type sx, sy, ex, ey;
      w = sb.eff_size(sb.width_reg);
      h = sb.eff_size(sb.height_reg);
      sx = pick_coord(w);
      sy = pick_coord(h);
      if ($urandom_range(0, 99) < 35) begin
         load_cell(sx, sy, load_value());
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               ex = sx;
               ey = sy;
            end
            1, 2, 3, 4: begin
               ex = pick_coord(w);
               ey = pick_coord(h);
            end
            default: begin
               ex = near_coord(sx);
               ey = near_coord(sy);
            end
         endcase
         run_query(sx, sy, ex, ey);
      end
   endtask

   initial begin
      int phase_len;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default 256 x 256 grid
      run_query(8'd0, 8'd0, 8'd0, 8'd0);
      run_query(8'd255, 8'd255, 8'd255, 8'd255);
      load_cell(8'd255, 8'd255, 8'h80);
      load_cell(8'd0, 8'd0, 8'd0);
      load_cell(8'd1, 8'd0, 8'd0);
      load_cell(8'd2, 8'd0, 8'h7F);
      load_cell(8'd0, 8'd1, 8'd0);
      run_query(8'd0, 8'd0, 8'd3, 8'd0);
      run_query(8'd0, 8'd0, 8'd2, 8'd0);
      run_query(8'd0, 8'd0, 8'd0, 8'd2);
      run_query(8'd255, 8'd255, 8'd254, 8'd253);
      run_query(8'd3, 8'd2, 8'd0, 8'd0);
      run_query(8'd1, 8'd4, 8'd0, 8'd0);

      // directed: 1 x 1 grid from zero registers
      settle(4);
      set_grid(9'd0, 9'd0);
      load_cell(8'd1, 8'd0, 8'h01);
      load_cell(8'd0, 8'd0, 8'h00);
      run_query(8'd0, 8'd0, 8'd0, 8'd0);
      run_query(8'd1, 8'd0, 8'd0, 8'd0);
      run_query(8'd0, 8'd1, 8'd0, 8'd0);
      run_query(8'd0, 8'd0, 8'd1, 8'd0);
      run_query(8'd0, 8'd0, 8'd0, 8'd1);
      run_query(8'd255, 8'd255, 8'd0, 8'd0);

      // directed: registers above the maximum clamp to 256
      settle(4);
      set_grid(9'd511, 9'd257);
      run_query(8'd255, 8'd255, 8'd0, 8'd1);
      run_query(8'd0, 8'd1, 8'd2, 8'd0);

      while (items < ItemTarget) begin
         settle(4);
         set_grid(pick_dim(), pick_dim());
         burst_mode = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(60, 200);
         for (int i = 0; i < phase_len && items < ItemTarget; i++) begin
            random_request();
            if ($urandom_range(0, 99) < 2) settle(1);
         end
      end

      settle(300);
      $display("covered %0d loads and %0d queries over %0d grid settings",
               sb.n_loads, sb.n_queries, phases);
      $display("responses: %0d clear, %0d out of range, %0d mismatches",
               sb.n_clear, sb.n_oor, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("grid_line_of_sight_check regression: pass");
      end else begin
         $display("grid_line_of_sight_check regression: fail");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("timeout with %0d requests outstanding", sb.pending());
      $display("grid_line_of_sight_check regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
